// File: sv/lnps_pkg.sv
// Shared types and constants for the last-note priority stack.
// Used by the interfaces, the stack cell, the core and its checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lnps_pkg;

  localparam int unsigned NOTE_W          = 7;
  localparam int unsigned ACTION_W        = 2;
  localparam int unsigned STACK_DEPTH_DEF = 128;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_ALL_OFF  = 2'd2
  } lnps_action_e;

  // One stack entry: a held note and whether the slot is occupied.
  typedef struct packed {
    logic              valid;
    logic [NOTE_W-1:0] note;
  } lnps_entry_t;

  // Command broadcast to every cell in the cycle a request is accepted.
  typedef struct packed {
    logic              en;
    lnps_action_e      action;
    logic [NOTE_W-1:0] note;
  } lnps_cmd_t;

endpackage

`default_nettype wire

// File: sv/lnps_if.sv
// Valid/ready channel interfaces for the request and result sides of the stack.
// Depends on lnps_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lnps_req_if;
  logic                          valid;
  logic                          ready;
  logic [lnps_pkg::ACTION_W-1:0] action;
  logic [lnps_pkg::NOTE_W-1:0]   note;

  modport source (output valid, output action, output note, input ready);
  modport sink   (input valid, input action, input note, output ready);
endinterface

interface lnps_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        latest_valid;
  logic [lnps_pkg::NOTE_W-1:0] latest_note;
  logic                        active_valid;
  logic [lnps_pkg::NOTE_W-1:0] active_note;

  modport source (output valid, output latest_valid, output latest_note,
                  output active_valid, output active_note, input ready);
  modport sink   (input valid, input latest_valid, input latest_note,
                  input active_valid, input active_note, output ready);
endinterface

`default_nettype wire

// File: sv/lnps_cell.sv
// One slot of the note stack: holds an entry and trades it with its neighbors.
// Depends on lnps_pkg for the entry and command types.
`timescale 1ns / 1ps
`default_nettype none

module lnps_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lnps_pkg::lnps_cmd_t   cmd_i,
  input  lnps_pkg::lnps_entry_t prev_i,
  input  lnps_pkg::lnps_entry_t next_i,
  input  wire                  hit_i,
  output logic                 hit_o,
  output lnps_pkg::lnps_entry_t ent_o,
  output lnps_pkg::lnps_entry_t ent_d_o
);

  logic                          valid_q;
  logic [lnps_pkg::NOTE_W-1:0]   note_q;
  lnps_pkg::lnps_entry_t         ent_q;
  lnps_pkg::lnps_entry_t         ent_d;
  logic                          match;

  assign ent_q.valid = valid_q;
  assign ent_q.note  = note_q;

  always_comb begin
    match = valid_q && (note_q == cmd_i.note);
    hit_o = hit_i | match;
    ent_d = ent_q;
    if (cmd_i.en) begin
      case (cmd_i.action)
        lnps_pkg::ACT_NOTE_ON: begin
          // Everything up to and including the old copy moves back one slot.
          if (!hit_i) begin
            ent_d = prev_i;
          end
        end
        lnps_pkg::ACT_NOTE_OFF: begin
          // Slots from the removed note onward pull the successor forward.
          if (hit_i || match) begin
            ent_d = next_i;
          end
        end
        lnps_pkg::ACT_ALL_OFF: begin
          ent_d.valid = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ent_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= ent_d.note;
  end

  assign ent_o   = ent_q;
  assign ent_d_o = ent_d;

endmodule

`default_nettype wire

// File: sv/last_note_priority_stack_core.sv
// Last-note priority stack core: a chain of stack cells plus the result register.
// Depends on lnps_pkg, the lnps_req_if / lnps_rsp_if interfaces and lnps_cell.
//
// Usage notes.
// The block keeps the held MIDI notes in order, newest first. Each request on
// req_i carries an action (note on, note off, all notes off) and a note number.
// A note on moves the note to the front or pushes it in, dropping the oldest
// entry when all STACK_DEPTH slots are full. A note off removes the note and
// closes the gap. All notes off empties the stack. An unused action code
// leaves the state alone but still yields a result.
// Every accepted request produces exactly one result on rsp_o in the cycle
// after, with the newest held note and the sticky active note after the event.
// The sticky note survives an empty stack and is only invalid until the first
// note on after reset.
// Throughput is one request per cycle: every cell compares its entry with the
// request note and shifts in parallel, so the whole stack updates in the cycle
// of acceptance. The result register decouples the sides; req_i.ready stays
// high while that register is empty or is being read in the same cycle, so a
// stalled receiver holds back at most one request.
// Reset empties the stack, clears the sticky note and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module last_note_priority_stack_core #(
  parameter int unsigned STACK_DEPTH = lnps_pkg::STACK_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lnps_req_if.sink    req_i,
  lnps_rsp_if.source  rsp_o
);

  lnps_pkg::lnps_cmd_t   cmd;
  lnps_pkg::lnps_entry_t ent    [STACK_DEPTH];
  lnps_pkg::lnps_entry_t ent_d  [STACK_DEPTH];
  lnps_pkg::lnps_entry_t prev_e [STACK_DEPTH];
  lnps_pkg::lnps_entry_t next_e [STACK_DEPTH];
  logic [STACK_DEPTH:0]  hit;

  logic                        accept;
  logic                        out_valid_q;
  logic                        latest_valid_q;
  logic [lnps_pkg::NOTE_W-1:0] latest_note_q;
  logic                        sticky_valid_q;
  logic                        sticky_valid_d;
  logic [lnps_pkg::NOTE_W-1:0] sticky_note_q;
  logic [lnps_pkg::NOTE_W-1:0] sticky_note_d;

  // The result register is free when empty or when it is read this cycle.
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign cmd.en     = accept;
  assign cmd.action = lnps_pkg::lnps_action_e'(req_i.action);
  assign cmd.note   = req_i.note;

  // The match chain runs from the front: cell i learns whether the note sits
  // in any newer slot.
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    // The front cell takes the incoming note on a push; the last cell pulls
    // in an empty slot when the stack closes a gap.
    if (i == 0) begin : g_front
      assign prev_e[i].valid = 1'b1;
      assign prev_e[i].note  = req_i.note;
    end else begin : g_mid
      assign prev_e[i] = ent[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_back
      assign next_e[i].valid = 1'b0;
      assign next_e[i].note  = '0;
    end else begin : g_inner
      assign next_e[i] = ent[i+1];
    end

    lnps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .prev_i  (prev_e[i]),
      .next_i  (next_e[i]),
      .hit_i   (hit[i]),
      .hit_o   (hit[i+1]),
      .ent_o   (ent[i]),
      .ent_d_o (ent_d[i])
    );
  end

  // The sticky note follows every note on, and follows the new front entry
  // after a note off as long as something is still held.
  always_comb begin
    sticky_valid_d = sticky_valid_q;
    sticky_note_d  = sticky_note_q;
    case (cmd.action)
      lnps_pkg::ACT_NOTE_ON: begin
        sticky_valid_d = 1'b1;
        sticky_note_d  = req_i.note;
      end
      lnps_pkg::ACT_NOTE_OFF: begin
        if (ent_d[0].valid) begin
          sticky_valid_d = 1'b1;
          sticky_note_d  = ent_d[0].note;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_valid_q <= 1'b0;
      sticky_note_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        sticky_valid_q <= sticky_valid_d;
        sticky_note_q  <= sticky_note_d;
        out_valid_q    <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q    <= 1'b0;
      end
    end
  end

  // Result payload, loaded with the state after the accepted event.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      latest_valid_q <= ent_d[0].valid;
      latest_note_q  <= ent_d[0].valid ? ent_d[0].note : '0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.latest_valid = latest_valid_q;
  assign rsp_o.latest_note  = latest_note_q;
  assign rsp_o.active_valid = sticky_valid_q;
  assign rsp_o.active_note  = sticky_note_q;

endmodule

`default_nettype wire

// File: sv/lnps_checker.sv
// Port-level checker for the last-note priority stack core, bound into the core module.
// Depends on lnps_pkg for widths and action codes.
`timescale 1ns / 1ps
`default_nettype none

module lnps_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          req_valid_i,
  input wire                          req_ready_i,
  input wire [lnps_pkg::ACTION_W-1:0] req_action_i,
  input wire [lnps_pkg::NOTE_W-1:0]   req_note_i,
  input wire                          rsp_valid_i,
  input wire                          rsp_ready_i,
  input wire                          rsp_latest_valid_i,
  input wire [lnps_pkg::NOTE_W-1:0]   rsp_latest_note_i,
  input wire                          rsp_active_valid_i,
  input wire [lnps_pkg::NOTE_W-1:0]   rsp_active_note_i
);

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_latest_valid_i) && $stable(rsp_latest_note_i) &&
      $stable(rsp_active_valid_i) && $stable(rsp_active_note_i))
    else $error("result payload changed while stalled");

  // Every accepted request yields a result in the next cycle.
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> rsp_valid_i)
    else $error("no result after an accepted request");

  // A note on puts the note at the front and makes it the active note.
  a_note_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_action_i == lnps_pkg::ACT_NOTE_ON) |=>
      rsp_latest_valid_i && (rsp_latest_note_i == $past(req_note_i)) &&
      rsp_active_valid_i && (rsp_active_note_i == $past(req_note_i)))
    else $error("note on did not reach the front");

  // All notes off leaves nothing held.
  a_all_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_action_i == lnps_pkg::ACT_ALL_OFF) |=>
      !rsp_latest_valid_i && (rsp_latest_note_i == '0))
    else $error("stack not empty after all notes off");

endmodule

bind last_note_priority_stack_core lnps_checker u_lnps_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .req_action_i       (req_i.action),
  .req_note_i         (req_i.note),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_latest_valid_i (rsp_o.latest_valid),
  .rsp_latest_note_i  (rsp_o.latest_note),
  .rsp_active_valid_i (rsp_o.active_valid),
  .rsp_active_note_i  (rsp_o.active_note)
);

`default_nettype wire

// File: sim/last_note_priority_stack_core_tb.sv
// Self-checking testbench for last_note_priority_stack_core: directed table, then random bursts.
// Depends on lnps_pkg, the lnps_req_if / lnps_rsp_if interfaces and the core with its cells.
`timescale 1ns / 1ps

module last_note_priority_stack_core_tb;
  import lnps_pkg::*;

  // The action code that the package leaves unnamed. The core must still answer it.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned HELD_DEPTH   = STACK_DEPTH_DEF;
  localparam int unsigned PHASE_EVENTS = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One result as the receiver sees it.
  typedef struct packed {
    logic              latest_valid;
    logic [NOTE_W-1:0] latest_note;
    logic              active_valid;
    logic [NOTE_W-1:0] active_note;
  } voice_state_t;

  // One row of the directed table. Where has_fixed is set, the expected result is typed in.
  // Otherwise the result comes from the voice predictor below.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [NOTE_W-1:0]   note;
    logic                has_fixed;
    voice_state_t        fixed_result;
  } midi_row_t;

  localparam int unsigned DIRECTED_ROWS = 23;

  // Walk through the opening cases: empty-stack events, the extreme note numbers, a repeat
  // press of the front note, a move from the back to the front, a release of a note that is
  // not held, releases at the front, middle and back, and the sticky note surviving an empty
  // stack after both a last release and all notes off. Note fields are ignored for all off.
  midi_row_t midi_rows [DIRECTED_ROWS] = '{
    '{ACT_NOTE_OFF, 7'd5,   1'b1, '{1'b0, 7'd0,   1'b0, 7'd0}},
    '{ACT_ALL_OFF,  7'd0,   1'b1, '{1'b0, 7'd0,   1'b0, 7'd0}},
    '{ACT_UNUSED,   7'd127, 1'b1, '{1'b0, 7'd0,   1'b0, 7'd0}},
    '{ACT_NOTE_ON,  7'd127, 1'b1, '{1'b1, 7'd127, 1'b1, 7'd127}},
    '{ACT_NOTE_ON,  7'd0,   1'b1, '{1'b1, 7'd0,   1'b1, 7'd0}},
    '{ACT_NOTE_ON,  7'd0,   1'b1, '{1'b1, 7'd0,   1'b1, 7'd0}},
    '{ACT_NOTE_ON,  7'd85,  1'b0, '0},
    '{ACT_NOTE_ON,  7'd42,  1'b0, '0},
    '{ACT_NOTE_ON,  7'd127, 1'b0, '0},
    '{ACT_NOTE_OFF, 7'd99,  1'b0, '0},
    '{ACT_NOTE_OFF, 7'd127, 1'b0, '0},
    '{ACT_NOTE_OFF, 7'd85,  1'b0, '0},
    '{ACT_NOTE_ON,  7'd127, 1'b0, '0},
    '{ACT_ALL_OFF,  7'd0,   1'b1, '{1'b0, 7'd0,   1'b1, 7'd127}},
    '{ACT_UNUSED,   7'd0,   1'b1, '{1'b0, 7'd0,   1'b1, 7'd127}},
    '{ACT_NOTE_OFF, 7'd42,  1'b1, '{1'b0, 7'd0,   1'b1, 7'd127}},
    '{ACT_NOTE_ON,  7'd1,   1'b1, '{1'b1, 7'd1,   1'b1, 7'd1}},
    '{ACT_NOTE_OFF, 7'd1,   1'b1, '{1'b0, 7'd0,   1'b1, 7'd1}},
    '{ACT_NOTE_ON,  7'd126, 1'b0, '0},
    '{ACT_NOTE_ON,  7'd64,  1'b0, '0},
    '{ACT_NOTE_OFF, 7'd126, 1'b0, '0},
    '{ACT_UNUSED,   7'd64,  1'b0, '0},
    '{ACT_ALL_OFF,  7'd127, 1'b1, '{1'b0, 7'd0,   1'b1, 7'd64}}
  };

  logic clk_i;
  logic rst_ni;

  lnps_req_if req_if ();
  lnps_rsp_if rsp_if ();

  last_note_priority_stack_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Predictor state: held notes newest first, how many are held, and the sticky voice note.
  logic [NOTE_W-1:0] held_notes [HELD_DEPTH];
  int unsigned       held_total;
  int unsigned       held_peak;
  logic              voice_valid;
  logic [NOTE_W-1:0] voice_note;

  // Results predicted for accepted requests, oldest first.
  voice_state_t pending_voices [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_ask;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned backpressure_cycles;
  int unsigned mismatch_count;

  // Clock with a 4 ns period.
  initial begin
    clk_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  // Apply one event to the predictor state and return the result the core must report.
  // With STACK_DEPTH equal to the number of MIDI notes, a press on a full stack always
  // finds its note already held, so it moves to the front and nothing drops off.
  function automatic voice_state_t predict_voice(input logic [ACTION_W-1:0] act,
                                                 input logic [NOTE_W-1:0] nt);
    voice_state_t res;
    int unsigned  pos;
    pos = held_total;
    for (int unsigned i = 0; i < held_total; i++) begin
      if (held_notes[i] == nt && pos == held_total) begin
        pos = i;
      end
    end
    case (act)
      ACT_NOTE_ON: begin
        if (pos == held_total) begin
          if (held_total < HELD_DEPTH) begin
            held_total++;
          end
          pos = held_total - 1;
        end
        for (int unsigned i = pos; i > 0; i--) begin
          held_notes[i] = held_notes[i - 1];
        end
        held_notes[0] = nt;
        voice_note    = nt;
        voice_valid   = 1'b1;
      end
      ACT_NOTE_OFF: begin
        if (pos < held_total) begin
          for (int unsigned i = pos; i + 1 < held_total; i++) begin
            held_notes[i] = held_notes[i + 1];
          end
          held_total--;
        end
        // The sticky note follows the front only while something is still held.
        if (held_total > 0) begin
          voice_note  = held_notes[0];
          voice_valid = 1'b1;
        end
      end
      ACT_ALL_OFF: begin
        held_total = 0;
      end
      default: begin
      end
    endcase
    if (held_total > held_peak) begin
      held_peak = held_total;
    end
    res.latest_valid = (held_total > 0);
    res.latest_note  = (held_total > 0) ? held_notes[0] : '0;
    res.active_valid = voice_valid;
    res.active_note  = voice_valid ? voice_note : '0;
    return res;
  endfunction

  // Offer one request, wait for its acceptance and queue the expected result. The valid
  // line is left high on return, so back-to-back requests never lower it in between.
  task automatic send_event(input logic [ACTION_W-1:0] act, input logic [NOTE_W-1:0] nt,
                            input logic use_fixed, input voice_state_t fixed_result);
    voice_state_t predicted;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_if.valid  <= 1'b0;
      req_if.action <= ACTION_W'($urandom);
      req_if.note   <= NOTE_W'($urandom);
      @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.note   <= nt;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    predicted = predict_voice(act, nt);
    pending_voices.push_back(use_fixed ? fixed_result : predicted);
    requests_sent++;
  endtask

  // Stop offering and wait until every expected result has been received.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (pending_voices.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One burst of random play. Most bursts are a hand on a few keys: presses and releases
  // of a small set of notes, which keeps hitting moves, front releases and empty stacks.
  // Some bursts press every note once in a shuffled order to fill the stack completely
  // and then play on the full stack. The rest is noise over every action and note.
  task automatic play_burst(input logic force_fill);
    int unsigned         kind;
    int unsigned         len;
    int unsigned         pool_size;
    int unsigned         r;
    int unsigned         j;
    int unsigned         tmp;
    int unsigned         order [HELD_DEPTH];
    logic [NOTE_W-1:0]   pool [8];
    logic [ACTION_W-1:0] act;
    kind = $urandom_range(99, 0);
    if (force_fill || kind < 6) begin
      for (int unsigned i = 0; i < HELD_DEPTH; i++) begin
        order[i] = i;
      end
      for (int unsigned i = HELD_DEPTH - 1; i > 0; i--) begin
        j        = $urandom_range(i, 0);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int unsigned i = 0; i < HELD_DEPTH; i++) begin
        send_event(ACT_NOTE_ON, NOTE_W'(order[i]), 1'b0, '0);
      end
      for (int unsigned i = 0; i < 20; i++) begin
        act = $urandom_range(1, 0) ? ACT_NOTE_ON : ACT_NOTE_OFF;
        send_event(act, NOTE_W'($urandom_range(127, 0)), 1'b0, '0);
      end
    end else if (kind < 75) begin
      pool_size = $urandom_range(8, 2);
      for (int unsigned i = 0; i < 8; i++) begin
        pool[i] = NOTE_W'($urandom_range(127, 0));
      end
      len = $urandom_range(40, 10);
      for (int unsigned i = 0; i < len; i++) begin
        r = $urandom_range(99, 0);
        if (r < 55) begin
          send_event(ACT_NOTE_ON, pool[$urandom_range(pool_size - 1, 0)], 1'b0, '0);
        end else if (r < 92) begin
          send_event(ACT_NOTE_OFF, pool[$urandom_range(pool_size - 1, 0)], 1'b0, '0);
        end else if (r < 96) begin
          send_event(ACT_ALL_OFF, NOTE_W'($urandom_range(127, 0)), 1'b0, '0);
        end else begin
          send_event(ACT_UNUSED, NOTE_W'($urandom_range(127, 0)), 1'b0, '0);
        end
      end
    end else begin
      len = $urandom_range(30, 10);
      for (int unsigned i = 0; i < len; i++) begin
        send_event(ACTION_W'($urandom_range(3, 0)), NOTE_W'($urandom_range(127, 0)),
                   1'b0, '0);
      end
    end
  endtask

  // Receiver: random ready, plus a long hold-off when the stimulus asks for one. The hold
  // is counted here so that the sender keeps offering requests while the core backs up.
  initial begin
    rsp_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_ask != 0) begin
        hold_left = hold_ask;
        hold_ask  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && !req_if.ready) begin
      backpressure_cycles++;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (pending_voices.size() == 0) begin
        $display("%0t: result with no request pending: latest %0d/%0d active %0d/%0d", $time,
                 rsp_if.latest_valid, rsp_if.latest_note, rsp_if.active_valid,
                 rsp_if.active_note);
        mismatch_count++;
      end else begin
        automatic voice_state_t want = pending_voices.pop_front();
        if (rsp_if.latest_valid !== want.latest_valid) begin
          $display("%0t: latest_valid expected %0d, got %0d", $time, want.latest_valid,
                   rsp_if.latest_valid);
          mismatch_count++;
        end
        if (rsp_if.latest_note !== want.latest_note) begin
          $display("%0t: latest_note expected %0d, got %0d", $time, want.latest_note,
                   rsp_if.latest_note);
          mismatch_count++;
        end
        if (rsp_if.active_valid !== want.active_valid) begin
          $display("%0t: active_valid expected %0d, got %0d", $time, want.active_valid,
                   rsp_if.active_valid);
          mismatch_count++;
        end
        if (rsp_if.active_note !== want.active_note) begin
          $display("%0t: active_note expected %0d, got %0d", $time, want.active_note,
                   rsp_if.active_note);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Main sequence: reset, then three idle patterns. The first pattern starts with the
  // directed table. Between patterns the sender pauses until every result has come back.
  // In the last pattern the receiver holds off for a long stretch while requests keep
  // coming, so the result register fills and the core stalls its input.
  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.action  = ACT_NOTE_ON;
    req_if.note    = '0;
    held_total     = 0;
    held_peak      = 0;
    voice_valid    = 1'b0;
    voice_note     = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_ask       = 0;
    cycle_count    = 0;
    requests_sent  = 0;
    results_seen   = 0;
    backpressure_cycles = 0;
    mismatch_count = 0;
    for (int unsigned i = 0; i < HELD_DEPTH; i++) begin
      held_notes[i] = '0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned phase = 0; phase < 3; phase++) begin
      automatic int unsigned phase_start;
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        for (int unsigned i = 0; i < DIRECTED_ROWS; i++) begin
          send_event(midi_rows[i].action, midi_rows[i].note, midi_rows[i].has_fixed,
                     midi_rows[i].fixed_result);
        end
      end

      phase_start = requests_sent;
      // After the directed table, the first pattern always goes on with a complete fill of the stack.
      play_burst(phase == 0);
      if (phase == 2) begin
        hold_ask = HOLD_CYCLES;
      end
      while (requests_sent - phase_start < PHASE_EVENTS) begin
        play_burst(1'b0);
      end
      wait_for_results();
    end

    // Idle on after the last result to catch anything extra from the core.
    repeat (8) @(posedge clk_i);
    mismatch_count += pending_voices.size();

    $display("Run covered %0d requests over three idle patterns and %0d checked results.",
             requests_sent, results_seen);
    $display("Stack peaked at %0d held notes; input stalled for %0d cycles.",
             held_peak, backpressure_cycles);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
